[rtl/sxfp_pkg.sv]
// Shared types and constants of the sync / length / XOR frame parser.
// No dependencies; sxfp_ctrl, sxfp_dp, the top level and the testbench import it.
package sxfp_pkg;

    localparam int MAX_PULSES_DEF = 64;

    localparam int TICK_W   = 20;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = 20;
    localparam int IDX_W    = 6;
    localparam int TOTAL_W  = 7;
    localparam int CNT_W    = 32;

    localparam logic [7:0] SYNC_A = 8'hAA;
    localparam logic [7:0] SYNC_B = 8'h55;
    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BYTE_TO   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ONLINE_TO = 2'd1;
    localparam logic [CFG_W-1:0] BYTE_TO_RST   = 20'd1000;
    localparam logic [CFG_W-1:0] ONLINE_TO_RST = 20'd5000;

    // result status codes
    localparam logic [1:0] ST_PULSE   = 2'd0;
    localparam logic [1:0] ST_LEN_ERR = 2'd1;
    localparam logic [1:0] ST_CRC_ERR = 2'd2;
    localparam logic [1:0] ST_TICK    = 2'd3;

    // item kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [IDX_W-1:0]   pulse_index;
        logic [15:0]        pulse_width;
        logic [TOTAL_W-1:0] pulse_total;
        logic               last;
        logic [CNT_W-1:0]   frame_seq;
        logic               link_online;
        logic [CNT_W-1:0]   good_frames;
        logic [CNT_W-1:0]   checksum_errors;
        logic [CNT_W-1:0]   length_errors;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic             step;   // process the held input item
        logic             rd;     // read pulse word at idx
        logic             ld;     // load pulse result into output register
        logic [IDX_W-1:0] idx;
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_pend;     // an input item is held
        logic out_free;    // output register can take a result this cycle
        logic frame_good;  // held item completes a good frame
        logic last_pulse;  // idx is the final pulse of the frame
    } t_ctrl_sts;

endpackage

[rtl/sxfp_stream_if.sv]
// Valid/ready channel carrying one item of payload type T.
// Depends on nothing; payload types come from sxfp_pkg.
interface sxfp_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/sxfp_ctrl.sv]
// Flow controller: steps held items and sequences the pulse readout.
// Depends on sxfp_pkg.
module sxfp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sxfp_pkg::t_ctrl_sts i_sts,
    output sxfp_pkg::t_ctrl_cmd o_cmd
);
    import sxfp_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        o_cmd      = '0;
        o_cmd.idx  = r_idx;
        case (r_state)
            S_IDLE: begin
                if (i_sts.in_pend && i_sts.out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_sts.frame_good) begin
                        n_state = S_READ;
                        n_idx   = '0;
                    end
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_LOAD;
            end
            S_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.ld = 1'b1;
                    if (i_sts.last_pulse) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

endmodule

[rtl/sxfp_dp.sv]
// Datapath: input holding register, parser state, payload memory,
// link supervision, saturating counters and the output register.
// Depends on sxfp_pkg and sxfp_stream_if.
module sxfp_dp #(
    parameter int MAX_PULSES = sxfp_pkg::MAX_PULSES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sxfp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sxfp_pkg::CFG_W-1:0]      i_cfg_data,
    input  sxfp_pkg::t_ctrl_cmd             i_cmd,
    output sxfp_pkg::t_ctrl_sts             o_sts,
    sxfp_stream_if.sink                     i_in,
    sxfp_stream_if.source                   o_out
);
    import sxfp_pkg::*;

    localparam int AW    = (MAX_PULSES > 1) ? $clog2(MAX_PULSES) : 1;
    localparam int DEPTH = 2 ** AW;

    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_SYNC2   = 3'd1;
    localparam logic [2:0] PH_LEN_LO  = 3'd2;
    localparam logic [2:0] PH_LEN_HI  = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_CHECK   = 3'd5;

    localparam logic [8:0] MAX_CNT = 9'(MAX_PULSES);

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // configuration
    logic [CFG_W-1:0] r_byte_to, r_online_to;

    // input holding register
    logic     r_in_valid;
    t_in_item r_in;

    // parser and supervision state
    logic [2:0]         r_phase, n_phase;
    logic [7:0]         r_cnt, n_cnt;       // pulse count, high byte checked zero
    logic [7:0]         r_pos, n_pos;
    logic [7:0]         r_xor, n_xor;
    logic [7:0]         r_lo;
    logic [TICK_W-1:0]  r_tsb, n_tsb, r_tsf, n_tsf;
    logic               r_online, n_online;
    logic [CNT_W-1:0]   r_seq, n_seq, r_good, n_good, r_crc, n_crc, r_len, n_len;
    logic [TOTAL_W-1:0] r_total;

    // payload words, low byte first
    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rd_data;
    logic        mem_we;

    logic          r_out_valid;
    t_out_item     r_out, n_out;
    logic          out_load;
    logic          restart, res_valid;
    logic [1:0]    res_status;
    logic          good_now;
    logic [TOTAL_W-1:0] idx_p1;

    assign o_sts.in_pend    = r_in_valid;
    assign o_sts.out_free   = !r_out_valid || o_out.ready;
    assign good_now         = (r_in.kind == KIND_BYTE) && (r_phase == PH_CHECK) &&
                              (r_in.data_byte == r_xor);
    assign o_sts.frame_good = good_now;
    assign idx_p1           = {1'b0, i_cmd.idx} + 1'b1;
    assign o_sts.last_pulse = (idx_p1 == r_total);

    assign i_in.ready  = !r_in_valid || i_cmd.step;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // one parser step on the held item
    always_comb begin
        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_pos      = r_pos;
        n_xor      = r_xor;
        n_tsb      = r_tsb;
        n_tsf      = r_tsf;
        n_online   = r_online;
        n_seq      = r_seq;
        n_good     = r_good;
        n_crc      = r_crc;
        n_len      = r_len;
        restart    = 1'b0;
        res_valid  = 1'b0;
        res_status = ST_TICK;
        mem_we     = 1'b0;
        if (i_cmd.step) begin
            if (r_in.kind == KIND_TICK) begin
                n_tsb = (r_tsb == TICK_MAX) ? r_tsb : r_tsb + 1'b1;
                n_tsf = (r_tsf == TICK_MAX) ? r_tsf : r_tsf + 1'b1;
                if (n_tsf > r_online_to) n_online = 1'b0;
                if (r_phase != PH_HUNT && n_tsb > r_byte_to) restart = 1'b1;
                res_valid  = 1'b1;
                res_status = ST_TICK;
            end else begin
                n_tsb = '0;
                case (r_phase)
                    PH_HUNT: begin
                        if (r_in.data_byte == SYNC_A) n_phase = PH_SYNC2;
                    end
                    PH_SYNC2: begin
                        if (r_in.data_byte == SYNC_B) begin
                            n_phase = PH_LEN_LO;
                            n_xor   = '0;
                            n_cnt   = '0;
                            n_pos   = '0;
                        end else if (r_in.data_byte != SYNC_A) begin
                            n_phase = PH_HUNT;
                        end
                    end
                    PH_LEN_LO: begin
                        n_cnt   = r_in.data_byte;
                        n_xor   = r_in.data_byte;
                        n_phase = PH_LEN_HI;
                    end
                    PH_LEN_HI: begin
                        n_xor = r_xor ^ r_in.data_byte;
                        if (r_in.data_byte != 8'd0 || r_cnt == 8'd0 ||
                            {1'b0, r_cnt} > MAX_CNT) begin
                            n_len      = sat_inc(r_len);
                            restart    = 1'b1;
                            res_valid  = 1'b1;
                            res_status = ST_LEN_ERR;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD: begin
                        mem_we = r_pos[0];
                        n_pos  = r_pos + 1'b1;
                        n_xor  = r_xor ^ r_in.data_byte;
                        if ({1'b0, n_pos} >= {r_cnt, 1'b0}) n_phase = PH_CHECK;
                    end
                    PH_CHECK: begin
                        if (!good_now) begin
                            n_crc      = sat_inc(r_crc);
                            res_valid  = 1'b1;
                            res_status = ST_CRC_ERR;
                        end else begin
                            n_seq    = r_seq + 1'b1;
                            n_good   = sat_inc(r_good);
                            n_tsf    = '0;
                            n_online = 1'b1;
                        end
                        restart = 1'b1;
                    end
                    default: begin
                        restart = 1'b1;
                    end
                endcase
            end
            if (restart) begin
                n_phase = PH_HUNT;
                n_cnt   = '0;
                n_pos   = '0;
                n_xor   = '0;
            end
        end
    end

    // result assembly
    always_comb begin
        n_out                 = '0;
        n_out.frame_seq       = n_seq;
        n_out.link_online     = n_online;
        n_out.good_frames     = n_good;
        n_out.checksum_errors = n_crc;
        n_out.length_errors   = n_len;
        n_out.last            = 1'b1;
        n_out.status          = res_status;
        if (i_cmd.ld) begin
            n_out.status      = ST_PULSE;
            n_out.pulse_index = i_cmd.idx;
            n_out.pulse_width = r_rd_data;
            n_out.pulse_total = r_total;
            n_out.last        = o_sts.last_pulse;
        end
    end

    assign out_load = i_cmd.ld || res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_to   <= BYTE_TO_RST;
            r_online_to <= ONLINE_TO_RST;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_HUNT;
            r_cnt       <= '0;
            r_pos       <= '0;
            r_xor       <= '0;
            r_tsb       <= '0;
            r_tsf       <= '0;
            r_online    <= 1'b0;
            r_seq       <= '0;
            r_good      <= '0;
            r_crc       <= '0;
            r_len       <= '0;
            r_total     <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_BYTE_TO)   r_byte_to   <= i_cfg_data;
                if (i_cfg_idx == REG_ONLINE_TO) r_online_to <= i_cfg_data;
            end
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (i_cmd.step) begin
                r_in_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_pos    <= n_pos;
            r_xor    <= n_xor;
            r_tsb    <= n_tsb;
            r_tsf    <= n_tsf;
            r_online <= n_online;
            r_seq    <= n_seq;
            r_good   <= n_good;
            r_crc    <= n_crc;
            r_len    <= n_len;
            if (i_cmd.step && good_now) r_total <= r_cnt[TOTAL_W-1:0];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) r_in <= i_in.data;
        if (out_load) r_out <= n_out;
        if (i_cmd.step && r_phase == PH_PAYLOAD && !r_pos[0]) r_lo <= r_in.data_byte;
    end

    // payload memory, one word written per byte pair
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[r_pos[AW:1]] <= {r_in.data_byte, r_lo};
        if (i_cmd.rd) r_rd_data <= r_mem[i_cmd.idx[AW-1:0]];
    end

endmodule

[rtl/sync_length_xor_frame_parser_top.sv]
// Top level of the sync / length / XOR frame parser.
// Depends on sxfp_pkg, sxfp_stream_if, sxfp_ctrl and sxfp_dp.
//
// Use:
//  - i_in carries items: kind 0 = a received UART byte, kind 1 = one time tick.
//  - o_out carries results: one tick report per tick, one status result per
//    length or checksum error, and one result per pulse of a good frame.
//  - The config port (i_cfg_we / i_cfg_idx / i_cfg_data) sets the byte
//    timeout (index 0) and the online timeout (index 1); write only while idle.
// Timing:
//  - An accepted item sits in a one-deep input register and is parsed when
//    the controller is idle and o_out can take a result; a status result it
//    causes is registered with that step, pulses via the READ and LOAD states.
//  - Bytes and ticks sustain one item per cycle while o_out keeps up.
//  - A good frame of N pulses reads the payload memory once per pulse, each
//    via READ then LOAD; no item is parsed until its last pulse is loaded.
// Reset (i_rst_n, synchronous): parser hunts for sync, counters and link
//  state clear, timeouts return to 1000 and 5000 ticks. No clearing pass.
// Stall: with o_out stalled, one more item is taken into the input register
//  and then i_in.ready drops until the waiting result is taken.
module sync_length_xor_frame_parser_top #(
    parameter int MAX_PULSES = sxfp_pkg::MAX_PULSES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sxfp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sxfp_pkg::CFG_W-1:0]     i_cfg_data,
    sxfp_stream_if.sink                    i_in,
    sxfp_stream_if.source                  o_out
);
    import sxfp_pkg::*;

    t_ctrl_cmd cmd;
    t_ctrl_sts sts;

    sxfp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    sxfp_dp #(
        .MAX_PULSES (MAX_PULSES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_in       (i_in),
        .o_out      (o_out)
    );

endmodule

[tb/sv/sync_length_xor_frame_parser_top_tb.sv]
// Self-checking testbench for sync_length_xor_frame_parser_top.
// Needs sxfp_pkg and sxfp_stream_if; an in-line parser model predicts every
// result, which is checked in order against o_out.
`timescale 1ns / 1ps

module sync_length_xor_frame_parser_top_tb;
    import sxfp_pkg::*;

    localparam int MAX_PULSES    = MAX_PULSES_DEF;
    // cycles for a held item to clear the input register and the parse stage
    localparam int SETTLE_CYCLES = 8;
    localparam int SHOWN_ERRORS  = 10;

    // indexes past the register list; the block must ignore them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    // parser phases of the model
    typedef enum logic [2:0] {
        PH_HUNT,
        PH_SYNC2,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_PAYLOAD,
        PH_CHECK
    } parse_phase_e;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    sxfp_stream_if #(.T(t_in_item))  in_if ();
    sxfp_stream_if #(.T(t_out_item)) out_if ();

    sync_length_xor_frame_parser_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // ------------------------------------------------------------------
    // Parser model state (mirrors the block after each accepted item)
    // ------------------------------------------------------------------
    parse_phase_e      m_phase;
    logic [15:0]       m_count;
    logic [7:0]        m_pos;
    logic [7:0]        m_xor;
    logic [7:0]        m_payload [128];
    logic [CNT_W-1:0]  m_seq;
    logic [CNT_W-1:0]  m_good;
    logic [CNT_W-1:0]  m_crc_fail;
    logic [CNT_W-1:0]  m_len_fail;
    logic [TICK_W-1:0] m_since_byte;
    logic [TICK_W-1:0] m_since_frame;
    logic              m_online;
    logic [CFG_W-1:0]  m_byte_to;
    logic [CFG_W-1:0]  m_online_to;

    // results the model has produced and o_out has not delivered yet
    t_out_item parser_reports [$];

    // stimulus knobs
    int        send_idle_pct;
    int        recv_idle_pct;
    int        tick_pct;
    int        n_sent;
    int        fail_count;
    logic [7:0] frame_bytes [128];

    // ------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // far beyond the slowest legal run (64-pulse frames under long stalls)
    initial begin
        #1_000_000;
        $display("sync_length_xor_frame_parser_top: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic void restart_parse();
        m_phase = PH_HUNT;
        m_count = '0;
        m_pos   = '0;
        m_xor   = '0;
    endfunction

    // counters and link state are taken after the item has been applied
    function automatic void push_report(input logic [1:0] st,
                                        input logic [IDX_W-1:0] idx,
                                        input logic [15:0] width,
                                        input logic [TOTAL_W-1:0] total,
                                        input logic lst);
        t_out_item r;
        r.status          = st;
        r.pulse_index     = idx;
        r.pulse_width     = width;
        r.pulse_total     = total;
        r.last            = lst;
        r.frame_seq       = m_seq;
        r.link_online     = m_online;
        r.good_frames     = m_good;
        r.checksum_errors = m_crc_fail;
        r.length_errors   = m_len_fail;
        parser_reports.push_back(r);
    endfunction

    function automatic void parse_item(input t_in_item it);
        logic [7:0] b;
        int         n;
        int         i;
        b = it.data_byte;
        if (it.kind == KIND_TICK) begin
            if (m_since_byte != TICK_MAX) m_since_byte = m_since_byte + 1'b1;
            if (m_since_frame != TICK_MAX) m_since_frame = m_since_frame + 1'b1;
            if (m_since_frame > m_online_to) m_online = 1'b0;
            if (m_phase != PH_HUNT && m_since_byte > m_byte_to) restart_parse();
            push_report(ST_TICK, '0, '0, '0, 1'b1);
            return;
        end
        m_since_byte = '0;
        case (m_phase)
            PH_HUNT: begin
                if (b == SYNC_A) m_phase = PH_SYNC2;
            end
            PH_SYNC2: begin
                if (b == SYNC_B) begin
                    m_phase = PH_LEN_LO;
                    m_xor   = '0;
                    m_count = '0;
                    m_pos   = '0;
                end else if (b != SYNC_A) begin
                    m_phase = PH_HUNT;
                end
            end
            PH_LEN_LO: begin
                m_count = {8'h00, b};
                m_xor   = b;
                m_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                m_count[15:8] = b;
                m_xor = m_xor ^ b;
                if (m_count == 0 || m_count > MAX_PULSES) begin
                    m_len_fail = sat_inc(m_len_fail);
                    restart_parse();
                    push_report(ST_LEN_ERR, '0, '0, '0, 1'b1);
                end else begin
                    m_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                m_payload[m_pos[6:0]] = b;
                m_pos = m_pos + 1'b1;
                m_xor = m_xor ^ b;
                if (int'(m_pos) >= 2 * int'(m_count)) m_phase = PH_CHECK;
            end
            PH_CHECK: begin
                if (b != m_xor) begin
                    m_crc_fail = sat_inc(m_crc_fail);
                    restart_parse();
                    push_report(ST_CRC_ERR, '0, '0, '0, 1'b1);
                end else begin
                    n             = int'(m_count);
                    m_seq         = m_seq + 1'b1;
                    m_good        = sat_inc(m_good);
                    m_since_frame = '0;
                    m_online      = 1'b1;
                    for (i = 0; i < n; i++) begin
                        push_report(ST_PULSE, IDX_W'(i),
                                    {m_payload[(2 * i + 1) % 128], m_payload[(2 * i) % 128]},
                                    TOTAL_W'(n), (i == n - 1));
                    end
                    restart_parse();
                end
            end
            default: restart_parse();
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    function automatic string fmt_report(input t_out_item r);
        return $sformatf({"st=%0d idx=%0d w=%h tot=%0d last=%0b seq=%0d on=%0b",
                          " good=%0d crc=%0d len=%0d"},
                         r.status, r.pulse_index, r.pulse_width, r.pulse_total,
                         r.last, r.frame_seq, r.link_online, r.good_frames,
                         r.checksum_errors, r.length_errors);
    endfunction

    function automatic void note_failure(input string what, input t_out_item want,
                                         input t_out_item got);
        fail_count++;
        if (fail_count <= SHOWN_ERRORS) begin
            $display("[%0t] %s", $time, what);
            $display("    expected %s", fmt_report(want));
            $display("    actual   %s", fmt_report(got));
        end
    endfunction

    function automatic void compare_report(input t_out_item got);
        t_out_item want;
        string     bad;
        if (parser_reports.size() == 0) begin
            note_failure("result with nothing expected", '0, got);
            return;
        end
        want = parser_reports.pop_front();
        bad  = "";
        if (got.status !== want.status)                 bad = {bad, " status"};
        if (got.pulse_index !== want.pulse_index)       bad = {bad, " pulse_index"};
        if (got.pulse_width !== want.pulse_width)       bad = {bad, " pulse_width"};
        if (got.pulse_total !== want.pulse_total)       bad = {bad, " pulse_total"};
        if (got.last !== want.last)                     bad = {bad, " last"};
        if (got.frame_seq !== want.frame_seq)           bad = {bad, " frame_seq"};
        if (got.link_online !== want.link_online)       bad = {bad, " link_online"};
        if (got.good_frames !== want.good_frames)       bad = {bad, " good_frames"};
        if (got.checksum_errors !== want.checksum_errors) bad = {bad, " checksum_errors"};
        if (got.length_errors !== want.length_errors)   bad = {bad, " length_errors"};
        if (bad != "") note_failure({"wrong field(s):", bad}, want, got);
    endfunction

    // Output side: sample the handshake as it stood before this edge, then
    // pick ready for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) compare_report(out_if.data);
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Stimulus primitives (all called at a rising edge)
    // ------------------------------------------------------------------
    // Present one item; valid only drops when a gap is drawn, so back-to-back
    // items never see valid lowered and raised in the same step.
    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        parse_item(it);
    endtask

    task automatic send_byte(input logic [7:0] b);
        t_in_item it;
        it.kind      = KIND_BYTE;
        it.data_byte = b;
        send_item(it);
        n_sent++;
    endtask

    task automatic send_tick();
        t_in_item it;
        it.kind      = KIND_TICK;
        it.data_byte = 8'($urandom);   // don't-care for ticks
        send_item(it);
        n_sent++;
    endtask

    // AA [AA..] 55 count_lo count_hi payload xor; stops after the count on a
    // length error. Payload comes from frame_bytes.
    task automatic send_frame(input int unsigned n_pulses, input int extra_sync,
                              input bit bad_sum);
        logic [15:0] cnt;
        logic [7:0]  sum;
        int          i;
        cnt = 16'(n_pulses);
        send_byte(SYNC_A);
        repeat (extra_sync) send_byte(SYNC_A);
        send_byte(SYNC_B);
        send_byte(cnt[7:0]);
        send_byte(cnt[15:8]);
        sum = cnt[7:0] ^ cnt[15:8];
        if (cnt == 0 || cnt > MAX_PULSES) return;
        for (i = 0; i < 2 * int'(n_pulses); i++) begin
            if ($urandom_range(99) < tick_pct) send_tick();
            send_byte(frame_bytes[i]);
            sum = sum ^ frame_bytes[i];
        end
        send_byte(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
    endtask

    task automatic fill_random_payload(input int n_pulses);
        int i;
        for (i = 0; i < 2 * n_pulses; i++) frame_bytes[i] = 8'($urandom);
    endtask

    // Hold the sender until every predicted result has been taken and the
    // parser has had time to swallow any trailing bytes.
    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (parser_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Only called with the block idle.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        if (idx == REG_BYTE_TO)   m_byte_to   = value;
        if (idx == REG_ONLINE_TO) m_online_to = value;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Tick straight out of reset: all counters zero, link offline.
    task automatic test_idle_tick();
        send_tick();
    endtask

    // Repeated AA before 55, two pulses at the width extremes.
    task automatic test_good_frame();
        frame_bytes[0] = 8'h00;
        frame_bytes[1] = 8'h00;
        frame_bytes[2] = 8'hFF;
        frame_bytes[3] = 8'hFF;
        send_frame(2, 1, 1'b0);
    endtask

    // Zero count and one past the pulse limit.
    task automatic test_length_errors();
        send_frame(0, 0, 1'b0);
        send_frame(MAX_PULSES + 1, 0, 1'b0);
    endtask

    task automatic test_checksum_error();
        frame_bytes[0] = 8'h12;
        frame_bytes[1] = 8'h34;
        send_frame(1, 0, 1'b1);
    endtask

    // Zero timeouts act on the first tick: the half-read frame is dropped
    // and the link goes offline. The bytes after it must be hunted over.
    task automatic test_timeouts();
        drain_results();
        write_register(REG_BYTE_TO, '0);
        write_register(REG_ONLINE_TO, '0);
        send_byte(SYNC_A);
        send_byte(SYNC_B);
        send_tick();
        send_byte(8'h01);
        send_byte(8'h00);
        drain_results();
        write_register(REG_BYTE_TO, CFG_W'(1_000_000));
        write_register(REG_ONLINE_TO, '1);
    endtask

    // Writes past the register list must leave both timeouts alone.
    task automatic test_spare_registers();
        drain_results();
        write_register(REG_SPARE_2, '1);
        write_register(REG_SPARE_3, '0);
        send_tick();
    endtask

    // Largest frame: 64 pulses, 128 payload bytes, one run of 64 results.
    task automatic test_full_frame();
        fill_random_payload(MAX_PULSES);
        frame_bytes[0] = 8'hFF;
        frame_bytes[1] = 8'hFF;
        frame_bytes[2 * MAX_PULSES - 2] = 8'h00;
        frame_bytes[2 * MAX_PULSES - 1] = 8'h00;
        tick_pct = 0;
        send_frame(MAX_PULSES, 0, 1'b0);
        drain_results();
    endtask

    // Mostly well-formed frames with random content, salted with checksum and
    // length errors, broken sync, tick bursts and noise.
    task automatic test_random_traffic(input int n_items, input int s_pct,
                                       input int r_pct,
                                       input logic [CFG_W-1:0] byte_to,
                                       input logic [CFG_W-1:0] online_to);
        int start;
        int pick;
        int n;
        t_in_item it;
        drain_results();
        write_register(REG_BYTE_TO, byte_to);
        write_register(REG_ONLINE_TO, online_to);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        tick_pct      = 8;
        start         = n_sent;
        while (n_sent - start < n_items) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                n = ($urandom_range(9) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 4);
                fill_random_payload(n);
                send_frame(n, ($urandom_range(4) == 0) ? $urandom_range(1, 3) : 0, 1'b0);
            end else if (pick < 65) begin
                n = $urandom_range(1, 4);
                fill_random_payload(n);
                send_frame(n, 0, 1'b1);
            end else if (pick < 75) begin
                n = $urandom_range(1) ? 0 : $urandom_range(MAX_PULSES + 1, 16'hFFFF);
                send_frame(n, 0, 1'b0);
            end else if (pick < 82) begin
                // sync broken by whatever follows the first AA
                send_byte(SYNC_A);
                send_byte(8'($urandom));
            end else if (pick < 92) begin
                repeat ($urandom_range(1, 6)) send_tick();
            end else begin
                // random noise bytes between frames; not counted as stimulus
                repeat ($urandom_range(1, 3)) begin
                    it.kind      = KIND_BYTE;
                    it.data_byte = 8'($urandom);
                    send_item(it);
                end
            end
            if ($urandom_range(14) == 0) drain_results();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        // block inputs known from time zero; ready comes from the checker
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= '0;
        i_cfg_data   <= '0;
        in_if.valid  <= 1'b0;
        in_if.data   <= '0;

        restart_parse();
        m_seq         = '0;
        m_good        = '0;
        m_crc_fail    = '0;
        m_len_fail    = '0;
        m_since_byte  = '0;
        m_since_frame = '0;
        m_online      = 1'b0;
        m_byte_to     = BYTE_TO_RST;
        m_online_to   = ONLINE_TO_RST;
        fail_count    = 0;
        n_sent        = 0;
        tick_pct      = 0;
        send_idle_pct = 17;
        recv_idle_pct = 47;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed checks under the first idle mix
        test_idle_tick();
        test_good_frame();
        test_length_errors();
        test_checksum_error();
        test_timeouts();
        test_spare_registers();

        // short timeouts so ticks inside frames abandon them and drop the link
        test_random_traffic(10, 17, 47, CFG_W'($urandom_range(1, 4)),
                            CFG_W'($urandom_range(2, 12)));

        send_idle_pct = 47;
        recv_idle_pct = 17;
        test_full_frame();
        test_random_traffic(10, 47, 17, CFG_W'(1_000_000), CFG_W'(1));

        test_random_traffic(10, 0, 0, '1, CFG_W'(1_000_000));

        drain_results();
        if (fail_count == 0) begin
            $display("sync_length_xor_frame_parser_top: match");
        end else begin
            $display("sync_length_xor_frame_parser_top: mismatch");
        end
        $finish;
    end

endmodule
